/* rtl/cbm_pkg.sv */
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

  // Work RAM size; must be a power of two (1024 to 8192).
  localparam int RAM_DEPTH = 8192;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [5:0] PRG_COUNT_RESET = 6'd16;

  // Request operations.
  typedef enum logic [2:0] {
    OP_CPU_READ     = 3'd0,
    OP_CPU_WRITE    = 3'd1,
    OP_VID_READ     = 3'd2,
    OP_VID_WRITE    = 3'd3,
    OP_SCANLINE     = 3'd4,
    OP_MAPPER_RESET = 3'd5
  } op_t;

  // CPU address regions, address[15:13].
  localparam logic [2:0] RGN_CHR      = 3'b000;
  localparam logic [2:0] RGN_WRAM     = 3'b011;
  localparam logic [2:0] RGN_BANK     = 3'b100;
  localparam logic [2:0] RGN_MIRROR   = 3'b101;
  localparam logic [2:0] RGN_IRQ_CNT  = 3'b110;
  localparam logic [2:0] RGN_IRQ_EN   = 3'b111;

  typedef struct packed {
    logic        handled;
    logic        from_ram;
    logic [18:0] mapped_address;
    logic [7:0]  read_data;
    logic        irq_pending;
    logic        mirror_horizontal;
  } result_t;

endpackage

/* rtl/cartridge_bank_mapper_irq.sv */
// Cartridge bank mapper with scanline interrupt counter: top level.
//
// Bank mapper with scanline IRQ counter. One request (CPU read/write, video
// read/write, scanline tick, mapper reset) is accepted per clock while in_stall
// is low. The result stage registers the work RAM read together with the
// translated address and the updated state; the result then moves into a
// two-entry output queue, so a stalled result does not hold up the next
// request until the queue and the result stage are both full. Sustained rate
// is one request per cycle while out_stall stays low and no clearing pass runs.
// Power-on reset and a mapper-reset request both start a clearing pass over the
// work RAM, one entry per cycle through its write port, during which in_stall
// is high. prg_bank_count writes are taken at any time, also during the pass;
// the fixed last banks follow it only at the next bank data write or mapper
// reset. Register writes (0x8000-0xFFFF) and protected RAM writes come back as not handled.
module cartridge_bank_mapper_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        handled,
  output logic        from_ram,
  output logic [18:0] mapped_address,
  output logic [7:0]  read_data,
  output logic        irq_pending,
  output logic        mirror_horizontal
);
  import cbm_pkg::*;

  // ---------------------------------------------------------------- state
  logic [5:0]        prg_bank_count;
  logic [2:0]        bank_target, bank_target_next;
  logic              prg_swap_mode, prg_swap_mode_next;
  logic              chr_invert, chr_invert_next;
  logic [7:0]        bank_values [8];
  logic [7:0]        bank_values_next [8];
  logic [5:0]        prg_bank [4];       // 8 KB program bank per CPU window
  logic [5:0]        prg_bank_next [4];
  logic [7:0]        chr_bank [8];       // 1 KB pattern bank per video window
  logic [7:0]        chr_bank_next [8];
  logic              mirror_mode, mirror_mode_next;
  logic              ram_read_off, ram_read_off_next;
  logic              ram_write_protect, ram_write_protect_next;
  logic [7:0]        irq_latch, irq_latch_next;
  logic [7:0]        irq_count, irq_count_next;
  logic              irq_on, irq_on_next;
  logic              irq_flag, irq_flag_next;

  // Work RAM and clearing pass
  logic [7:0]        work_ram [RAM_DEPTH];
  logic [7:0]        ram_q;
  logic              clearing;
  logic [RAM_AW-1:0] clear_cnt;
  logic [RAM_AW-1:0] ram_index;
  logic              ram_we;
  logic              ram_rd;
  logic              start_clear;

  // Result stage and output queue
  logic              accept;
  logic              p_valid;
  result_t           p_res;
  result_t           res_next;
  logic              p_ram_sel, ram_sel_next;
  result_t           fifo [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        cnt;
  logic              push, pop;
  result_t           push_res;

  logic [5:0]        fixed2, fixed1;
  logic              rebuild;
  logic [7:0]        pair [4];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = clearing || (p_valid && (cnt == 2'd2));
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign push      = p_valid && (cnt != 2'd2);
  assign ram_index = address[RAM_AW-1:0];

  // Fixed last banks: 2*count-2 and 2*count-1, mod 64.
  assign fixed2 = {prg_bank_count[4:0] - 5'd1, 1'b0};
  assign fixed1 = {prg_bank_count[4:0] - 5'd1, 1'b1};

  // --------------------------------------------------- per-request logic
  always_comb begin
    bank_target_next       = bank_target;
    prg_swap_mode_next     = prg_swap_mode;
    chr_invert_next        = chr_invert;
    bank_values_next       = bank_values;
    prg_bank_next          = prg_bank;
    chr_bank_next          = chr_bank;
    mirror_mode_next       = mirror_mode;
    ram_read_off_next      = ram_read_off;
    ram_write_protect_next = ram_write_protect;
    irq_latch_next         = irq_latch;
    irq_count_next         = irq_count;
    irq_on_next            = irq_on;
    irq_flag_next          = irq_flag;
    ram_we                 = 1'b0;
    ram_rd                 = 1'b0;
    start_clear            = 1'b0;
    rebuild                = 1'b0;
    ram_sel_next           = 1'b0;
    res_next               = '0;
    pair                   = '{default: 8'd0};

    if (accept) begin
      case (op_t'(operation))
        OP_CPU_READ: begin
          if (address[15:13] == RGN_WRAM) begin
            if (!ram_read_off) begin
              res_next.handled  = 1'b1;
              res_next.from_ram = 1'b1;
              ram_rd            = 1'b1;
              ram_sel_next      = 1'b1;
            end
          end else if (address[15]) begin
            res_next.handled        = 1'b1;
            res_next.mapped_address = {prg_bank[address[14:13]], address[12:0]};
          end
        end
        OP_CPU_WRITE: begin
          if (address[15:13] == RGN_WRAM) begin
            if (!ram_write_protect) begin
              ram_we            = 1'b1;
              res_next.handled  = 1'b1;
              res_next.from_ram = 1'b1;
            end
          end else if (address[15]) begin
            case (address[15:13])
              RGN_BANK: begin
                if (!address[0]) begin
                  bank_target_next   = write_data[2:0];
                  prg_swap_mode_next = write_data[6];
                  chr_invert_next    = write_data[7];
                end else begin
                  bank_values_next[bank_target] = write_data;
                  rebuild = 1'b1;
                end
              end
              RGN_MIRROR: begin
                if (!address[0]) begin
                  mirror_mode_next = write_data[0];
                end else begin
                  ram_read_off_next      = !write_data[7];
                  ram_write_protect_next = write_data[6];
                end
              end
              RGN_IRQ_CNT: begin
                if (!address[0]) irq_latch_next = write_data;
                else             irq_count_next = 8'd0;
              end
              RGN_IRQ_EN: begin
                if (!address[0]) begin
                  irq_on_next   = 1'b0;
                  irq_flag_next = 1'b0;
                end else begin
                  irq_on_next = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        OP_VID_READ: begin
          if (address[15:13] == RGN_CHR) begin
            res_next.handled        = 1'b1;
            res_next.mapped_address = {1'b0, chr_bank[address[12:10]], address[9:0]};
          end
        end
        OP_VID_WRITE: ;
        OP_SCANLINE: begin
          if (irq_count == 8'd0) irq_count_next = irq_latch;
          else                   irq_count_next = irq_count - 8'd1;
          if ((irq_count_next == 8'd0) && irq_on) irq_flag_next = 1'b1;
        end
        OP_MAPPER_RESET: begin
          start_clear            = 1'b1;
          bank_target_next       = 3'd0;
          prg_swap_mode_next     = 1'b0;
          chr_invert_next        = 1'b0;
          bank_values_next       = '{default: 8'd0};
          chr_bank_next          = '{default: 8'd0};
          prg_bank_next[0]       = 6'd0;
          prg_bank_next[1]       = 6'd1;
          prg_bank_next[2]       = fixed2;
          prg_bank_next[3]       = fixed1;
          mirror_mode_next       = 1'b1;
          ram_read_off_next      = 1'b0;
          ram_write_protect_next = 1'b0;
          irq_latch_next         = 8'd0;
          irq_count_next         = 8'd0;
          irq_on_next            = 1'b0;
          irq_flag_next          = 1'b0;
        end
        default: ;
      endcase
    end

    // Bank data write: rebuild every window from the updated bank registers.
    if (rebuild) begin
      pair[0] = bank_values_next[0] & 8'hFE;
      pair[1] = bank_values_next[0] | 8'h01;
      pair[2] = bank_values_next[1] & 8'hFE;
      pair[3] = bank_values_next[1] | 8'h01;
      for (int i = 0; i < 4; i++) begin
        chr_bank_next[i]   = chr_invert ? bank_values_next[2 + i] : pair[i];
        chr_bank_next[4 + i] = chr_invert ? pair[i] : bank_values_next[2 + i];
      end
      prg_bank_next[0] = prg_swap_mode ? fixed2 : bank_values_next[6][5:0];
      prg_bank_next[2] = prg_swap_mode ? bank_values_next[6][5:0] : fixed2;
      prg_bank_next[1] = bank_values_next[7][5:0];
      prg_bank_next[3] = fixed1;
    end

    res_next.irq_pending       = irq_flag_next;
    res_next.mirror_horizontal = mirror_mode_next;
  end

  // ------------------------------------------------------ mapper registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
    end else if (cfg_write) begin
      prg_bank_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_target       <= 3'd0;
      prg_swap_mode     <= 1'b0;
      chr_invert        <= 1'b0;
      bank_values       <= '{default: 8'd0};
      chr_bank          <= '{default: 8'd0};
      prg_bank[0]       <= 6'd0;
      prg_bank[1]       <= 6'd1;
      prg_bank[2]       <= {PRG_COUNT_RESET[4:0] - 5'd1, 1'b0};
      prg_bank[3]       <= {PRG_COUNT_RESET[4:0] - 5'd1, 1'b1};
      mirror_mode       <= 1'b1;
      ram_read_off      <= 1'b0;
      ram_write_protect <= 1'b0;
      irq_latch         <= 8'd0;
      irq_count         <= 8'd0;
      irq_on            <= 1'b0;
      irq_flag          <= 1'b0;
    end else begin
      bank_target       <= bank_target_next;
      prg_swap_mode     <= prg_swap_mode_next;
      chr_invert        <= chr_invert_next;
      bank_values       <= bank_values_next;
      chr_bank          <= chr_bank_next;
      prg_bank          <= prg_bank_next;
      mirror_mode       <= mirror_mode_next;
      ram_read_off      <= ram_read_off_next;
      ram_write_protect <= ram_write_protect_next;
      irq_latch         <= irq_latch_next;
      irq_count         <= irq_count_next;
      irq_on            <= irq_on_next;
      irq_flag          <= irq_flag_next;
    end
  end

  // ------------------------------------------------------- clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (start_clear) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + 1'b1;
      if (clear_cnt == RAM_AW'(RAM_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  // ------------------------------------------------------------ work RAM
  always_ff @(posedge clk) begin
    if (clearing) begin
      work_ram[clear_cnt] <= 8'd0;
    end else if (ram_we) begin
      work_ram[ram_index] <= write_data;
    end
    if (ram_rd) begin
      ram_q <= work_ram[ram_index];
    end
  end

  // ------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (push) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res     <= res_next;
      p_ram_sel <= ram_sel_next;
    end
  end

  // Fold the registered RAM byte in on the way to the queue.
  always_comb begin
    push_res           = p_res;
    push_res.read_data = p_ram_sel ? ram_q : 8'd0;
  end

  // ------------------------------------------------ two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= push_res;
  end

  assign handled           = fifo[rd_ptr].handled;
  assign from_ram          = fifo[rd_ptr].from_ram;
  assign mapped_address    = fifo[rd_ptr].mapped_address;
  assign read_data         = fifo[rd_ptr].read_data;
  assign irq_pending       = fifo[rd_ptr].irq_pending;
  assign mirror_horizontal = fifo[rd_ptr].mirror_horizontal;

  // ----------------------------------------------------------- assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output queue count out of range");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_MAPPER_RESET)) |=> (clearing && (clear_cnt == '0)))
    else $error("mapper reset did not start a clearing pass");

  a_irq_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_flag) |-> $past(accept && (operation == OP_SCANLINE)))
    else $error("irq raised without a scanline tick");

  a_unhandled_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !handled) |-> ((mapped_address == 19'd0) && (read_data == 8'd0)))
    else $error("unhandled result carries data");

endmodule
